[hdl/urxb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urxb_pkg
// Shared constants of the UART receive line and FIFO buffer: operating modes,
// item kinds, character codes and the default store depth.
// ----------------------------------------------------------------------------
package urxb_pkg;

    // Default number of bytes in the shared line / FIFO store
    localparam int URXB_DEPTH_DEFAULT = 256;

    // Operating modes (work_mode register)
    localparam logic [1:0] MODE_LINE = 2'd0;
    localparam logic [1:0] MODE_FIFO = 2'd2;

    // Item kinds
    localparam logic [1:0] KIND_RX   = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_LINE = 2'd2;

    // Character codes
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_T  = 8'h74;

    // "rese": the four bytes that must precede 't' to spell "reset"
    localparam logic [31:0] WORD_RESE = 32'h7265_7365;

endpackage

[hdl/uart_rx_line_and_fifo_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_line_and_fifo_buffer
// Receive-side buffer of a serial console: command-line assembly, transfer
// FIFO and detection of the word "reset", over one shared byte store.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle; busy is always low. Each
// accepted item gives exactly one result, shown for one cycle with o_strobe
// high in the cycle after the item was taken. The receiver cannot stall, so
// it must take every result in the cycle it appears. The byte store is a
// single-port memory with registered read data; its write for an item lands
// at the accepting edge, so a pop or line read issued in the next cycle
// already sees it. The store is not cleared at reset: read only entries that
// were written. Change work_mode only while no item is in flight.
// ----------------------------------------------------------------------------
module uart_rx_line_and_fifo_buffer #(
    parameter int BUFFER_DEPTH = urxb_pkg::URXB_DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,

    // Configuration
    input  logic       i_work_mode_we,
    input  logic [1:0] i_work_mode,

    // Item input
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_line_index,

    // Result output
    output logic       o_strobe,
    output logic       o_echo_valid,
    output logic [7:0] o_echo_byte,
    output logic       o_line_done,
    output logic [7:0] o_line_length,
    output logic       o_too_long,
    output logic       o_magic_reset,
    output logic       o_fifo_dropped,
    output logic       o_read_valid,
    output logic [7:0] o_read_byte
);
    import urxb_pkg::*;

    localparam int PW = $clog2(BUFFER_DEPTH);
    localparam logic [PW-1:0] LAST_POS = PW'(BUFFER_DEPTH - 1);

    // Line index wrap table: entry v holds v modulo BUFFER_DEPTH
    typedef logic [255:0][PW-1:0] t_idx_map;

    function automatic t_idx_map f_build_map();
        t_idx_map m;
        int       r;
        m = '0;
        r = 0;
        for (int i = 0; i < 256; i++) begin
            m[i] = PW'(r);
            r    = (r == BUFFER_DEPTH - 1) ? 0 : r + 1;
        end
        return m;
    endfunction

    localparam t_idx_map IDX_MAP = f_build_map();

    // State
    logic [1:0]    r_work_mode;
    logic [PW-1:0] r_line_pos, n_line_pos;
    logic [PW-1:0] r_fifo_head, n_fifo_head;
    logic [PW-1:0] r_fifo_tail, n_fifo_tail;
    logic [31:0]   r_recent, n_recent;

    // Store
    logic [7:0]    r_mem [BUFFER_DEPTH];
    logic [7:0]    r_rd_data;
    logic          mem_we, mem_re;
    logic [PW-1:0] mem_addr;
    logic [7:0]    mem_wdata;

    // Result register
    logic       r_strobe;
    logic       r_echo_valid, n_echo_valid;
    logic [7:0] r_echo_byte, n_echo_byte;
    logic       r_line_done, n_line_done;
    logic [7:0] r_line_length, n_line_length;
    logic       r_too_long, n_too_long;
    logic       r_magic, n_magic;
    logic       r_dropped, n_dropped;
    logic       r_read_valid, n_read_valid;

    logic          accept;
    logic [PW-1:0] tail_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign tail_next = (r_fifo_tail == LAST_POS) ? '0 : r_fifo_tail + 1'b1;

    // Per-item decode: next state, store access and result flags
    always_comb begin
        n_line_pos    = r_line_pos;
        n_fifo_head   = r_fifo_head;
        n_fifo_tail   = r_fifo_tail;
        n_recent      = r_recent;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_addr      = r_line_pos;
        mem_wdata     = i_rx_byte;
        n_echo_valid  = 1'b0;
        n_echo_byte   = '0;
        n_line_done   = 1'b0;
        n_line_length = '0;
        n_too_long    = 1'b0;
        n_magic       = 1'b0;
        n_dropped     = 1'b0;
        n_read_valid  = 1'b0;

        unique case (i_kind)
            KIND_RX: begin
                n_magic  = (r_recent == WORD_RESE) && (i_rx_byte == CH_T);
                n_recent = {r_recent[23:0], i_rx_byte};
                if (r_work_mode == MODE_LINE) begin
                    if (i_rx_byte == CH_LF) begin
                        // line feed is ignored
                    end else if (r_line_pos == LAST_POS && i_rx_byte != CH_CR) begin
                        n_too_long = 1'b1;
                        n_line_pos = '0;
                    end else if (i_rx_byte == CH_CR) begin
                        mem_we        = 1'b1;
                        mem_wdata     = '0;
                        n_line_done   = 1'b1;
                        n_line_length = 8'(r_line_pos);
                        n_line_pos    = '0;
                    end else begin
                        mem_we       = 1'b1;
                        n_line_pos   = r_line_pos + 1'b1;
                        n_echo_valid = 1'b1;
                        n_echo_byte  = i_rx_byte;
                    end
                end else if (r_work_mode == MODE_FIFO) begin
                    mem_addr = r_fifo_tail;
                    if (tail_next == r_fifo_head) begin
                        n_dropped = 1'b1;
                    end else begin
                        mem_we      = 1'b1;
                        n_fifo_tail = tail_next;
                    end
                end
            end
            KIND_POP: begin
                mem_addr = r_fifo_head;
                if (r_fifo_head != r_fifo_tail) begin
                    mem_re       = 1'b1;
                    n_read_valid = 1'b1;
                    n_fifo_head  = (r_fifo_head == LAST_POS) ? '0 : r_fifo_head + 1'b1;
                end
            end
            KIND_LINE: begin
                mem_addr     = IDX_MAP[i_line_index];
                mem_re       = 1'b1;
                n_read_valid = 1'b1;
            end
            default: begin
                // unused kind: no effect, all-zero result
            end
        endcase
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work_mode <= MODE_LINE;
        end else if (i_work_mode_we) begin
            r_work_mode <= i_work_mode;
        end
    end

    // Pointers and receive window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pos  <= '0;
            r_fifo_head <= '0;
            r_fifo_tail <= '0;
            r_recent    <= '0;
        end else if (accept) begin
            r_line_pos  <= n_line_pos;
            r_fifo_head <= n_fifo_head;
            r_fifo_tail <= n_fifo_tail;
            r_recent    <= n_recent;
        end
    end

    // Byte store, single port, registered read
    always_ff @(posedge i_clk) begin
        if (accept && mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (accept && mem_re) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= accept;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_echo_valid  <= n_echo_valid;
            r_echo_byte   <= n_echo_byte;
            r_line_done   <= n_line_done;
            r_line_length <= n_line_length;
            r_too_long    <= n_too_long;
            r_magic       <= n_magic;
            r_dropped     <= n_dropped;
            r_read_valid  <= n_read_valid;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_echo_valid   = r_echo_valid;
    assign o_echo_byte    = r_echo_byte;
    assign o_line_done    = r_line_done;
    assign o_line_length  = r_line_length;
    assign o_too_long     = r_too_long;
    assign o_magic_reset  = r_magic;
    assign o_fifo_dropped = r_dropped;
    assign o_read_valid   = r_read_valid;
    assign o_read_byte    = r_read_valid ? r_rd_data : 8'h00;

    // Assertions
    a_one_result_per_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_strobe)
        else $error("accepted item gave no result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_strobe)
        else $error("result without an accepted item");

    a_exclusive_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $onehot0({o_echo_valid, o_line_done, o_too_long,
                               o_fifo_dropped, o_read_valid}))
        else $error("more than one outcome for one item");

    a_echo_matches_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_echo_valid |-> o_echo_byte == $past(i_rx_byte))
        else $error("echoed byte differs from received byte");

    a_read_from_read_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_read_valid |-> ($past(i_kind) == KIND_POP || $past(i_kind) == KIND_LINE))
        else $error("read data for an item that does not read");

    a_pointers_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_head <= LAST_POS && r_fifo_tail <= LAST_POS && r_line_pos <= LAST_POS)
        else $error("store pointer beyond the store");

endmodule
